>>> hw/rtl/npcs_pkg.sv
// ----------------------------------------------------------------------------
// npcs_pkg
// Shared types, constants and the distance function for the nearest palette
// color search block.
// ----------------------------------------------------------------------------
package npcs_pkg;

  // Palette geometry
  localparam int PALETTE_DEPTH = 256;
  localparam int IDX_W         = $clog2(PALETTE_DEPTH);
  localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);

  // Request and result field widths
  localparam int RGB_W   = 24;
  localparam int SLOT_W  = 8;
  localparam int COUNT_W = 9;
  localparam int NIDX_W  = 8;

  // Largest weighted distance is 9 * 255^2 = 585225, fits in 20 bits
  localparam int DIST_W = 20;

  // Request opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Absolute difference of two 8-bit channels
  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  // Weighted squared distance 3*dr^2 + 4*dg^2 + 2*db^2
  function automatic logic [DIST_W-1:0] weighted_dist(input logic [RGB_W-1:0] a,
                                                      input logic [RGB_W-1:0] b);
    logic [7:0]        dr;
    logic [7:0]        dg;
    logic [7:0]        db;
    logic [15:0]       sr;
    logic [15:0]       sg;
    logic [15:0]       sb;
    logic [DIST_W-1:0] acc;
    dr  = abs_diff(a[23:16], b[23:16]);
    dg  = abs_diff(a[15:8], b[15:8]);
    db  = abs_diff(a[7:0], b[7:0]);
    sr  = dr * dr;
    sg  = dg * dg;
    sb  = db * db;
    acc = (DIST_W'(sr) << 1) + DIST_W'(sr) + (DIST_W'(sg) << 2) + (DIST_W'(sb) << 1);
    weighted_dist = acc;
  endfunction

endpackage

>>> hw/rtl/nearest_palette_color_search.sv
// Nearest palette color search. The block holds a palette in a single-port
// synchronous RAM, written one entry per load request. A query request
// brings a color and a search count N (0 is taken as 1, values above the
// palette depth are clipped) and returns the index of the closest of the
// first N entries under 3*dr^2 + 4*dg^2 + 2*db^2, lower index on a tie.
// A query reads one palette entry per cycle from the RAM and occupies the
// block for its N reads, the RAM read register, the distance stage, the
// compare and the hand-off to the result register. New requests are taken
// while an earlier result waits to be read; a query that finishes while
// that result is still unread holds in its hand-off cycle until the result
// is taken. Reading an entry that was never loaded gives an undefined
// index.
// ----------------------------------------------------------------------------
// nearest_palette_color_search
// Palette RAM, scan sequencer, distance stage and running minimum.
// ----------------------------------------------------------------------------
module nearest_palette_color_search
  import npcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               req_valid,
  output logic               req_ready,
  input  logic               opcode,
  input  logic [SLOT_W-1:0]  entry_index,
  input  logic [RGB_W-1:0]   rgb_value,
  input  logic [COUNT_W-1:0] search_count,
  // result channel
  output logic               res_valid,
  input  logic               res_ready,
  output logic [NIDX_W-1:0]  nearest_index
);

  // Palette storage
  logic [RGB_W-1:0] pal_mem [PALETTE_DEPTH];

  state_t state;
  state_t state_next;

  logic              req_fire;
  logic              wr_en;
  logic              rd_en;
  logic              res_load;
  logic              scan_last;

  logic [RGB_W-1:0]  query_rgb;
  logic [CNT_W-1:0]  scan_cnt;
  logic [CNT_W-1:0]  scan_cnt_next;
  logic [CNT_W-1:0]  issue_cnt;

  // pipeline: RAM read, distance, compare
  logic              rd_vld;
  logic [RGB_W-1:0]  rd_data;
  logic [IDX_W-1:0]  rd_idx;
  logic              dist_vld;
  logic [DIST_W-1:0] step_dist;
  logic [IDX_W-1:0]  dist_idx;
  logic              best_first;
  logic [DIST_W-1:0] best_dist;
  logic [IDX_W-1:0]  best_idx;

  assign req_fire  = req_valid && req_ready;
  assign scan_last = (issue_cnt == scan_cnt - CNT_W'(1));

  // Clamp the query count to 1..PALETTE_DEPTH
  always_comb begin
    if (search_count == '0) begin
      scan_cnt_next = CNT_W'(1);
    end else if (32'(search_count) > PALETTE_DEPTH) begin
      scan_cnt_next = CNT_W'(PALETTE_DEPTH);
    end else begin
      scan_cnt_next = CNT_W'(search_count);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_fire && opcode == OP_QUERY) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!rd_vld && !dist_vld) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!res_valid || res_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    req_ready = 1'b0;
    rd_en     = 1'b0;
    res_load  = 1'b0;
    case (state)
      ST_IDLE:  req_ready = 1'b1;
      ST_SCAN:  rd_en     = 1'b1;
      ST_DRAIN: ;
      ST_DONE:  res_load  = !res_valid || res_ready;
      default:  ;
    endcase
  end

  assign wr_en = req_fire && (opcode == OP_LOAD) && (32'(entry_index) < PALETTE_DEPTH);

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      issue_cnt  <= '0;
      rd_vld     <= 1'b0;
      dist_vld   <= 1'b0;
      best_first <= 1'b1;
      res_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      rd_vld   <= rd_en;
      dist_vld <= rd_vld;
      if (req_fire && opcode == OP_QUERY) begin
        issue_cnt  <= '0;
        best_first <= 1'b1;
      end else begin
        if (rd_en) issue_cnt <= issue_cnt + CNT_W'(1);
        if (dist_vld) best_first <= 1'b0;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Query capture
  always_ff @(posedge clk) begin
    if (req_fire && opcode == OP_QUERY) begin
      query_rgb <= rgb_value;
      scan_cnt  <= scan_cnt_next;
    end
  end

  // Palette RAM: write on load, registered read during the scan
  always_ff @(posedge clk) begin
    if (wr_en) pal_mem[IDX_W'(entry_index)] <= rgb_value;
    if (rd_en) begin
      rd_data <= pal_mem[issue_cnt[IDX_W-1:0]];
      rd_idx  <= issue_cnt[IDX_W-1:0];
    end
  end

  // Distance stage
  always_ff @(posedge clk) begin
    if (rd_vld) begin
      step_dist <= weighted_dist(query_rgb, rd_data);
      dist_idx  <= rd_idx;
    end
  end

  // Running minimum, strict compare keeps the lower index on a tie
  always_ff @(posedge clk) begin
    if (dist_vld && (best_first || step_dist < best_dist)) begin
      best_dist <= step_dist;
      best_idx  <= dist_idx;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (res_load) nearest_index <= NIDX_W'(best_idx);
  end

endmodule

>>> hw/rtl/npcs_chk.sv
// ----------------------------------------------------------------------------
// npcs_chk
// Port-level checks for the nearest palette color search block.
// ----------------------------------------------------------------------------
module npcs_chk
  import npcs_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               opcode,
  input logic               res_valid,
  input logic               res_ready,
  input logic [NIDX_W-1:0]  nearest_index
);

  // A pending result stays offered
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped before it was taken");

  // A pending result keeps its index
  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(nearest_index))
    else $error("result index changed while stalled");

  // A query request occupies the block for the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && opcode == OP_QUERY |=> !req_ready)
    else $error("request taken while a query scan runs");

  // A load request never stalls the next request
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && opcode == OP_LOAD |=> req_ready)
    else $error("load request stalled the request channel");

endmodule

bind nearest_palette_color_search npcs_chk u_npcs_chk (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req_valid),
  .req_ready     (req_ready),
  .opcode        (opcode),
  .res_valid     (res_valid),
  .res_ready     (res_ready),
  .nearest_index (nearest_index)
);
